### hw/rtl/rcht_pkg.sv
// Shared types and constants for the page reference count hash table.
// No dependencies; every file of the block but the stream interface and the slot store imports it.
package rcht_pkg;

  // Page address width (the table key)
  localparam int ADDR_W = 56;
  // Width of the reported reference count
  localparam int REF_W = 16;
  // Hash fold width before reduction to the table size
  localparam int HASH_W = 16;

  // Slot count codes: empty, tombstone, first live value
  localparam int COUNT_EMPTY = 0;
  localparam int COUNT_TOMB  = 1;
  localparam int COUNT_LIVE  = 2;

  // Command codes; the unused code behaves as a query
  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_SATURATED = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CHECK,
    ST_ACT
  } rcht_state_t;

  // Request beat
  typedef struct packed {
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] page_addr;
  } req_t;

  // Response beat
  typedef struct packed {
    logic             other_refs;
    logic [REF_W-1:0] ref_value;
    logic [1:0]       status;
  } rsp_t;

endpackage

### hw/rtl/rcht_stream_if.sv
// Valid/ready stream channel carrying one payload beat per handshake.
// Payload type is a parameter; the block uses rcht_pkg::req_t and rsp_t.
interface rcht_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/page_refcount_hash_table_top.sv
// Page reference count table, open addressing with linear probing.
// A request passes the home unit, then one slot read and check per probed slot,
// from 1 to CAPACITY slots; remove or query on an empty table probes none.
// No new request is taken until the last one's result is registered for the
// response, as the single probe compare unit walks the slot store slot by slot.
// Reset: synchronous; then a clearing pass over every slot, no requests taken.
module page_refcount_hash_table_top #(
  parameter int CAPACITY = 128,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  // streams
  rcht_stream_if.sink         req,
  rcht_stream_if.source       rsp
);
  import rcht_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int EW = ADDR_W + COUNT_WIDTH;

  logic [ADDR_W-1:0] shared_page;
  logic              cfg_we;
  logic              home_start;
  logic              home_done;
  logic [AW-1:0]     home;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [EW-1:0]     mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [EW-1:0]     mem_rdata;
  req_t              req_data;
  rsp_t              rsp_data;
  logic              rsp_valid;
  logic              req_ready;

  // Zero page register at byte offset 0
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && !paddr[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      shared_page <= '0;
    end else if (cfg_we) begin
      shared_page <= pwdata[ADDR_W-1:0];
    end
  end

  assign prdata = paddr[3] ? 64'b0 : 64'(shared_page);

  // Stream hookup
  assign req_data    = req.payload;
  assign req.ready   = req_ready;
  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_data;

  rcht_home #(
    .CAPACITY (CAPACITY)
  ) u_home (
    .clk       (clk),
    .rst       (rst),
    .start     (home_start),
    .page_addr (req_data.page_addr),
    .done      (home_done),
    .home      (home)
  );

  rcht_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rcht_ctrl #(
    .CAPACITY    (CAPACITY),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .shared_page (shared_page),
    .req_valid   (req.valid),
    .req_data    (req_data),
    .req_ready   (req_ready),
    .rsp_valid   (rsp_valid),
    .rsp_data    (rsp_data),
    .rsp_ready   (rsp.ready),
    .home_start  (home_start),
    .home_done   (home_done),
    .home        (home),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

endmodule

### hw/rtl/rcht_home.sv
// Home slot unit: folds a page address to 16 bits and reduces it modulo
// the table capacity over three registered stages. Uses rcht_pkg.
module rcht_home #(
  parameter int CAPACITY = 128,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rcht_pkg::ADDR_W-1:0] page_addr,
  output logic                      done,
  output logic [AW-1:0]             home
);
  import rcht_pkg::*;

  // Reciprocal for an exact 16-bit quotient by the capacity
  localparam int Shift = HASH_W + $clog2(CAPACITY);
  localparam logic [17:0] Recip = 18'(((1 << Shift) + CAPACITY - 1) / CAPACITY);

  logic [2:0]        vld;
  logic [HASH_W-1:0] fold;
  logic [HASH_W-1:0] fold_d;
  logic [HASH_W-1:0] quot;
  logic [33:0]       prod;
  logic [31:0]       rem;
  logic [31:0]       rem_fix;

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], start};
    end
  end

  // Fold the address into 16 bits
  always_ff @(posedge clk) begin
    if (start) begin
      fold <= page_addr[15:0] ^ page_addr[31:16] ^ page_addr[47:32]
            ^ {8'b0, page_addr[55:48]};
    end
  end

  // Quotient by reciprocal multiply
  assign prod = 34'(fold) * 34'(Recip);

  always_ff @(posedge clk) begin
    if (vld[0]) begin
      quot   <= 16'(prod >> Shift);
      fold_d <= fold;
    end
  end

  // Remainder with one corrective subtract
  assign rem     = 32'(fold_d) - 32'(quot) * 32'(CAPACITY);
  assign rem_fix = (rem >= 32'(CAPACITY)) ? rem - 32'(CAPACITY) : rem;

  always_ff @(posedge clk) begin
    if (vld[1]) begin
      home <= rem_fix[AW-1:0];
    end
  end

  assign done = vld[2];

endmodule

### hw/rtl/rcht_mem.sv
// Slot store: one write port and one read port with registered read data.
// Holds each slot's key and count packed together. No package use.
module rcht_mem #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 72,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/rcht_ctrl.sv
// Probe sequencer: clears the slot store, walks slots from the home slot
// with one shared compare unit, then applies the command. Uses rcht_pkg.
module rcht_ctrl #(
  parameter int CAPACITY = 128,
  parameter int COUNT_WIDTH = 16,
  localparam int AW = $clog2(CAPACITY),
  localparam int LW = $clog2(CAPACITY + 1),
  localparam int EW = rcht_pkg::ADDR_W + COUNT_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [rcht_pkg::ADDR_W-1:0] shared_page,
  // request side
  input  logic                        req_valid,
  input  rcht_pkg::req_t              req_data,
  output logic                        req_ready,
  // response side
  output logic                        rsp_valid,
  output rcht_pkg::rsp_t              rsp_data,
  input  logic                        rsp_ready,
  // home slot unit
  output logic                        home_start,
  input  logic                        home_done,
  input  logic [AW-1:0]               home,
  // slot store
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [EW-1:0]               mem_wdata,
  output logic [AW-1:0]               mem_raddr,
  input  logic [EW-1:0]               mem_rdata
);
  import rcht_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam logic [AW-1:0] LastIdx = AW'(CAPACITY - 1);

  rcht_state_t       state, state_next;
  logic [AW-1:0]     clr_idx;
  logic [1:0]        cmd;
  logic [ADDR_W-1:0] page;
  logic [AW-1:0]     probe_idx;
  logic [AW-1:0]     probe_cnt;
  logic              free_seen;
  logic [AW-1:0]     free_idx;
  logic              hit;
  logic [AW-1:0]     hit_idx;
  logic [CW-1:0]     hit_cnt;
  logic [LW-1:0]     live;

  logic              req_fire;
  logic              act_fire;
  logic              skip_probe;

  // Probe compare unit
  logic [ADDR_W-1:0] ent_key;
  logic [CW-1:0]     ent_cnt;
  logic              ent_free;
  logic              ent_match;
  logic              probe_stop;
  logic [AW-1:0]     probe_idx_inc;

  // Command update
  logic              act_we;
  logic [AW-1:0]     act_waddr;
  logic [CW-1:0]     act_cnt;
  logic [CW-1:0]     act_val;
  logic [1:0]        act_status;
  logic              live_inc;
  logic              live_dec;
  logic [32:0]       val_wide;
  logic [REF_W-1:0]  ref_sat;

  assign req_fire   = req_valid && req_ready;
  assign act_fire   = (state == ST_ACT) && (!rsp_valid || rsp_ready);
  assign skip_probe = (cmd != CMD_ADD) && (live == '0);

  assign ent_key       = mem_rdata[EW-1:CW];
  assign ent_cnt       = mem_rdata[CW-1:0];
  assign ent_free      = (ent_cnt <= CW'(COUNT_TOMB));
  assign ent_match     = !ent_free && (ent_key == page);
  assign probe_stop    = ent_match || (ent_cnt == CW'(COUNT_EMPTY)) || (probe_cnt == LastIdx);
  assign probe_idx_inc = (probe_idx == LastIdx) ? '0 : probe_idx + AW'(1);

  // Decide the slot update and the result
  always_comb begin
    act_we     = 1'b0;
    act_waddr  = hit_idx;
    act_cnt    = hit_cnt;
    act_val    = '0;
    act_status = STAT_DONE;
    live_inc   = 1'b0;
    live_dec   = 1'b0;
    case (cmd)
      CMD_ADD: begin
        if (hit) begin
          if (hit_cnt == {CW{1'b1}}) begin
            act_status = STAT_SATURATED;
            act_val    = hit_cnt;
          end else begin
            act_we  = 1'b1;
            act_cnt = hit_cnt + CW'(1);
            act_val = act_cnt;
          end
        end else if (free_seen) begin
          act_we    = 1'b1;
          act_waddr = free_idx;
          act_cnt   = CW'(COUNT_LIVE);
          act_val   = act_cnt;
          live_inc  = 1'b1;
        end else begin
          act_status = STAT_FULL;
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          act_we  = 1'b1;
          act_cnt = hit_cnt - CW'(1);
          if (act_cnt == CW'(COUNT_TOMB)) begin
            live_dec = 1'b1;
          end else begin
            act_val = act_cnt;
          end
        end else begin
          act_status = STAT_NOT_FOUND;
        end
      end
      default: begin
        if (hit) begin
          act_val = hit_cnt;
        end else if (page != shared_page) begin
          act_status = STAT_NOT_FOUND;
        end
      end
    endcase
  end

  // Clip the count to the reported width
  assign val_wide = 33'(act_val);
  assign ref_sat  = (val_wide > 33'hFFFF) ? {REF_W{1'b1}} : val_wide[REF_W-1:0];

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_idx == LastIdx) state_next = ST_IDLE;
      ST_IDLE:  if (req_fire) state_next = ST_HASH;
      ST_HASH:  if (home_done) state_next = skip_probe ? ST_ACT : ST_READ;
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: state_next = probe_stop ? ST_ACT : ST_READ;
      ST_ACT:   if (act_fire) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs to the handshake, the home unit and the store
  always_comb begin
    req_ready  = (state == ST_IDLE);
    home_start = req_fire;
    mem_raddr  = probe_idx;
    mem_we     = 1'b0;
    mem_waddr  = act_waddr;
    mem_wdata  = {page, act_cnt};
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = '0;
      end
      ST_ACT: begin
        mem_we = act_fire && act_we;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      live      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + AW'(1);
      end
      if (act_fire && live_inc) begin
        live <= live + LW'(1);
      end else if (act_fire && live_dec) begin
        live <= live - LW'(1);
      end
      if (act_fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Item and probe registers
  always_ff @(posedge clk) begin
    if (req_fire) begin
      cmd  <= req_data.cmd;
      page <= req_data.page_addr;
    end
    if (state == ST_HASH && home_done) begin
      probe_idx <= home;
      probe_cnt <= '0;
      free_seen <= 1'b0;
      hit       <= 1'b0;
    end
    if (state == ST_CHECK) begin
      if (ent_match) begin
        hit     <= 1'b1;
        hit_idx <= probe_idx;
        hit_cnt <= ent_cnt;
      end else if (ent_free && !free_seen) begin
        free_seen <= 1'b1;
        free_idx  <= probe_idx;
      end
      if (!probe_stop) begin
        probe_idx <= probe_idx_inc;
        probe_cnt <= probe_cnt + AW'(1);
      end
    end
    if (act_fire) begin
      rsp_data.other_refs <= (page == shared_page) || (act_val >= CW'(COUNT_LIVE));
      rsp_data.ref_value  <= ref_sat;
      rsp_data.status     <= act_status;
    end
  end

endmodule

### tb/sv/page_refcount_hash_table_checker.sv
// Scoreboard for the page reference count table: tracks the zero-page register
// and predicts every response beat. Depends on rcht_pkg and rcht_stream_if.
module page_refcount_hash_table_checker #(
  parameter int CAPACITY = 128,
  parameter int COUNT_WIDTH = 16,
  parameter logic [3:0] SHARED_PAGE_REG = 4'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  rcht_stream_if      req,
  rcht_stream_if      rsp,
  output int unsigned pending,
  output int unsigned fail_count
);
  import rcht_pkg::*;

  localparam int unsigned COUNT_MAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);
  localparam int unsigned REF_MAX = (1 << REF_W) - 1;

  typedef struct packed {
    req_t item;
    rsp_t want;
  } ref_expect_t;

  // Shadow of the table and the zero-page register
  logic [ADDR_W-1:0] slot_key[CAPACITY];
  int unsigned       slot_count[CAPACITY];
  int unsigned       live_slots;
  logic [ADDR_W-1:0] shared_page;
  ref_expect_t       refcount_due[$];
  int unsigned       errors = 0;

  assign fail_count = errors;

  // Fold the page address into the hash width, then reduce to a slot
  function automatic int home_slot(logic [ADDR_W-1:0] page);
    logic [HASH_W-1:0] fold;
    fold = page[15:0] ^ page[31:16] ^ page[47:32] ^ {8'h00, page[55:48]};
    return int'(fold) % CAPACITY;
  endfunction

  // Walk from home until an empty slot; return the live slot holding page
  function automatic int live_slot_of(logic [ADDR_W-1:0] page);
    int idx;
    int found;
    found = -1;
    for (int i = 0; i < CAPACITY; i++) begin
      idx = (home_slot(page) + i) % CAPACITY;
      if (slot_count[idx] == COUNT_EMPTY) break;
      if (slot_count[idx] >= COUNT_LIVE && slot_key[idx] == page) begin
        found = idx;
        break;
      end
    end
    return found;
  endfunction

  // First empty or tombstone slot from home
  function automatic int free_slot_for(logic [ADDR_W-1:0] page);
    int idx;
    int found;
    found = -1;
    for (int i = 0; i < CAPACITY; i++) begin
      idx = (home_slot(page) + i) % CAPACITY;
      if (slot_count[idx] <= COUNT_TOMB) begin
        found = idx;
        break;
      end
    end
    return found;
  endfunction

  // Apply one command to the shadow table and return the response it owes
  function automatic rsp_t apply_ref_cmd(logic [1:0] cmd, logic [ADDR_W-1:0] page);
    int          slot;
    int unsigned val;
    status_t     st;
    rsp_t        r;
    st = STAT_DONE;
    val = 0;
    slot = -1;
    case (cmd)
      CMD_ADD: begin
        slot = live_slot_of(page);
        if (slot >= 0) begin
          if (slot_count[slot] >= COUNT_MAX) st = STAT_SATURATED;
          else slot_count[slot]++;
        end else begin
          slot = free_slot_for(page);
          if (slot >= 0) begin
            slot_key[slot] = page;
            slot_count[slot] = COUNT_LIVE;
            live_slots++;
          end else begin
            st = STAT_FULL;
          end
        end
      end
      CMD_REMOVE: begin
        slot = (live_slots != 0) ? live_slot_of(page) : -1;
        if (slot >= 0) begin
          slot_count[slot]--;
          if (slot_count[slot] == COUNT_TOMB) live_slots--;
        end else begin
          st = STAT_NOT_FOUND;
        end
      end
      // query, and the spare code that behaves as one
      default: begin
        slot = (live_slots != 0) ? live_slot_of(page) : -1;
        if (slot < 0 && page != shared_page) st = STAT_NOT_FOUND;
      end
    endcase
    if (slot >= 0 && slot_count[slot] >= COUNT_LIVE) val = slot_count[slot];
    if (val > REF_MAX) val = REF_MAX;
    r.other_refs = (page == shared_page) || (val >= COUNT_LIVE);
    r.ref_value = val[REF_W-1:0];
    r.status = st;
    return r;
  endfunction

  // Retire response beats first, then predict newly accepted request beats
  always @(posedge clk) begin : watch
    rsp_t        got;
    ref_expect_t due;
    req_t        item;
    if (rst) begin
      for (int i = 0; i < CAPACITY; i++) begin
        slot_key[i] = '0;
        slot_count[i] = COUNT_EMPTY;
      end
      live_slots = 0;
      shared_page = '0;
      refcount_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == SHARED_PAGE_REG)
        shared_page = pwdata[ADDR_W-1:0];
      if (rsp.valid && rsp.ready) begin
        got = rsp.payload;
        if (refcount_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("refcount: unexpected beat other_refs %0b ref_value %0d status %0d",
                     got.other_refs, got.ref_value, got.status);
        end else begin
          due = refcount_due.pop_front();
          if (got.other_refs != due.want.other_refs || got.ref_value != due.want.ref_value ||
              got.status != due.want.status) begin
            errors++;
            if (errors <= 10)
              $display({"refcount mismatch cmd %0d page %h: expected other_refs %0b ",
                        "ref_value %0d status %0d, got other_refs %0b ref_value %0d status %0d"},
                       due.item.cmd, due.item.page_addr, due.want.other_refs,
                       due.want.ref_value, due.want.status, got.other_refs, got.ref_value,
                       got.status);
          end
        end
      end
      if (req.valid && req.ready) begin
        item = req.payload;
        due.item = item;
        due.want = apply_ref_cmd(item.cmd, item.page_addr);
        refcount_due.push_back(due);
      end
    end
    pending <= refcount_due.size();
  end

endmodule

### tb/sv/page_refcount_hash_table_top_tb.sv
// Top of the page reference count table bench: clock, reset, request stimulus,
// register writes, response back-pressure and verdict. Uses the checker module.
module page_refcount_hash_table_top_tb;
  import rcht_pkg::*;

  localparam int SLOTS = 128;
  localparam int COUNT_BITS = 16;
  localparam logic [3:0] REG_SHARED_PAGE = 4'd0;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int unsigned POOL_SIZE = 32;
  localparam int unsigned FILL_PAGES = 136;
  localparam int unsigned DRAIN_LIMIT = 200000;
  localparam logic [ADDR_W-1:0] PAGE_ALL_ONES = '1;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  int unsigned pending;
  int unsigned fail_count;

  int unsigned       beats_sent = 0;
  int unsigned       tx_idle_pct = 0;
  int unsigned       rx_idle_pct = 0;
  bit                stall_ask = 1'b0;
  logic [ADDR_W-1:0] page_pool[POOL_SIZE];
  logic [ADDR_W-1:0] fill_pages[FILL_PAGES];
  logic [ADDR_W-1:0] zero_now;

  rcht_stream_if #(.payload_t(req_t)) req_ch ();
  rcht_stream_if #(.payload_t(rsp_t)) rsp_ch ();

  page_refcount_hash_table_top #(
    .CAPACITY(SLOTS),
    .COUNT_WIDTH(COUNT_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  page_refcount_hash_table_checker #(
    .CAPACITY(SLOTS),
    .COUNT_WIDTH(COUNT_BITS),
    .SHARED_PAGE_REG(REG_SHARED_PAGE)
  ) scoreboard (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .pready(pready),
    .req(req_ch),
    .rsp(rsp_ch),
    .pending(pending),
    .fail_count(fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Safety net against a hung handshake
  initial begin
    #200_000_000;
    $display("page_refcount_hash_table_top test failed");
    $finish;
  end

  // Drive response ready: random idling, plus one long hold-off on request
  initial begin : rx_drive
    int unsigned stall_left;
    bit          stall_done;
    stall_left = 0;
    stall_done = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_ask && !stall_done) begin
        stall_left = 400;
        stall_done = 1'b1;
      end
      if (stall_left != 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Build a random page whose address folds onto the given home slot
  function automatic logic [ADDR_W-1:0] page_at_home(int unsigned home);
    logic [7:0]  c3;
    logic [15:0] c2, c1, c0, fold;
    c3 = 8'($urandom);
    c2 = 16'($urandom);
    c1 = 16'($urandom);
    fold = 16'($urandom_range(0, (65536 / SLOTS) - 1) * SLOTS + home);
    c0 = fold ^ c2 ^ c1 ^ {8'h00, c3};
    return {c3, c2, c1, c0};
  endfunction

  function automatic logic [ADDR_W-1:0] noise_page();
    return {24'($urandom), 32'($urandom)};
  endfunction

  // Mostly clustered pool pages, some noise, now and then the zero page
  function automatic logic [ADDR_W-1:0] pick_page();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return noise_page();
    if (r < 11) return zero_now;
    return page_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  function automatic logic [1:0] random_cmd();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return CMD_ADD;
    if (r < 75) return CMD_REMOVE;
    if (r < 95) return CMD_QUERY;
    return CMD_SPARE;
  endfunction

  // Offer one request beat, idling first at the sender's rate
  task automatic send_ref(logic [1:0] cmd, logic [ADDR_W-1:0] page);
    req_t beat;
    beat.cmd = cmd;
    beat.page_addr = page;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.payload <= beat;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  // Drop valid and wait until every response has come back
  task automatic settle();
    int unsigned waited;
    waited = 0;
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // Two-phase register write of the zero-page address
  task automatic write_shared_page(logic [ADDR_W-1:0] page);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_SHARED_PAGE;
    pwdata <= {{(64 - ADDR_W){1'b0}}, page};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    zero_now = page;
  endtask

  // Reference bursts on one page with random content, mixed with loose commands
  task automatic random_phase(int unsigned count);
    int unsigned       start;
    int unsigned       n;
    logic [ADDR_W-1:0] page;
    start = beats_sent;
    while (beats_sent - start < count) begin
      page = pick_page();
      if ($urandom_range(99) < 60) begin
        n = $urandom_range(1, 4);
        repeat (n) send_ref(CMD_ADD, page);
        send_ref(CMD_QUERY, page);
        repeat ($urandom_range(0, n + 1)) send_ref(CMD_REMOVE, page);
      end else begin
        send_ref(random_cmd(), page);
      end
    end
  endtask

  initial begin : stimulus
    logic [ADDR_W-1:0] zp, a1, a2, a3, w1, w2, sat_page;
    int unsigned       home;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    zero_now = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Clustered pool: one cluster straddles the last slot so probes wrap
    for (int c = 0; c < 4; c++) begin
      home = (c == 0) ? SLOTS - 2 : $urandom_range(SLOTS - 1);
      for (int i = 0; i < 8; i++)
        page_pool[c * 8 + i] = page_at_home((home + (i % 2)) % SLOTS);
    end
    zp = page_at_home(5);
    a1 = page_at_home(40);
    a2 = page_at_home(40);
    a3 = page_at_home(40);
    w1 = page_at_home(SLOTS - 1);
    w2 = page_at_home(SLOTS - 1);

    // Directed: empty table, extremes, zero page, collisions, wrap, tombstones
    write_shared_page(zp);
    send_ref(CMD_QUERY, zp);
    send_ref(CMD_REMOVE, a1);
    send_ref(CMD_QUERY, a1);
    send_ref(CMD_ADD, PAGE_ALL_ONES);
    send_ref(CMD_ADD, '0);
    send_ref(CMD_ADD, PAGE_ALL_ONES);
    send_ref(CMD_QUERY, PAGE_ALL_ONES);
    send_ref(CMD_ADD, zp);
    send_ref(CMD_REMOVE, zp);
    send_ref(CMD_QUERY, zp);
    send_ref(CMD_REMOVE, zp);
    send_ref(CMD_ADD, a1);
    send_ref(CMD_ADD, a2);
    send_ref(CMD_ADD, a3);
    send_ref(CMD_REMOVE, a1);
    send_ref(CMD_QUERY, a2);
    send_ref(CMD_ADD, a1);
    send_ref(CMD_SPARE, a3);
    send_ref(CMD_ADD, w1);
    send_ref(CMD_ADD, w2);
    send_ref(CMD_QUERY, w2);
    send_ref(CMD_REMOVE, PAGE_ALL_ONES);
    send_ref(CMD_REMOVE, PAGE_ALL_ONES);
    send_ref(CMD_QUERY, PAGE_ALL_ONES);
    send_ref(CMD_REMOVE, '0);

    // Random: slow sender against a mostly stalled receiver
    settle();
    write_shared_page('0);
    tx_idle_pct = 26;
    rx_idle_pct = 70;
    random_phase(220);

    // Random: the other way round
    settle();
    write_shared_page(PAGE_ALL_ONES);
    tx_idle_pct = 70;
    rx_idle_pct = 26;
    random_phase(220);

    // Random at full rate, opening with a long receiver hold-off
    settle();
    write_shared_page(page_pool[3]);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    stall_ask = 1'b1;
    random_phase(220);

    // Overfill the table, then drain it back to tombstones
    settle();
    sat_page = noise_page();
    write_shared_page(sat_page);
    for (int i = 0; i < FILL_PAGES; i++) begin
      fill_pages[i] = noise_page();
      send_ref(CMD_ADD, fill_pages[i]);
    end
    for (int i = 0; i < FILL_PAGES; i++)
      send_ref(CMD_REMOVE, fill_pages[i]);

    // Pile references onto one page, then step one back
    repeat (40) send_ref(CMD_ADD, sat_page);
    send_ref(CMD_QUERY, sat_page);
    send_ref(CMD_REMOVE, sat_page);
    send_ref(CMD_QUERY, sat_page);

    settle();
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("page_refcount_hash_table_top test passed");
    end else begin
      $display("page_refcount_hash_table_top test failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/rcht_pkg.sv
hw/rtl/rcht_stream_if.sv
hw/rtl/rcht_home.sv
hw/rtl/rcht_mem.sv
hw/rtl/rcht_ctrl.sv
hw/rtl/page_refcount_hash_table_top.sv
tb/sv/page_refcount_hash_table_checker.sv
tb/sv/page_refcount_hash_table_top_tb.sv
